// ===== rtl/core/tod_pkg.sv =====
`default_nettype none

package tod_pkg;

  // Field and register widths
  localparam int unsigned ACCEL_W  = 10;
  localparam int unsigned THR_W    = 9;
  localparam int unsigned NORM_W   = 10;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned NUM_AXES = 3;

  // One axis squared reaches 512^2, the sum of three stays below 2^20,
  // and (norm_low+1)^2 reaches 1024^2.
  localparam int unsigned SQ_W    = 19;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned LO_SQ_W = 21;
  localparam int unsigned HI_SQ_W = 20;

  // Register reset values
  localparam logic [THR_W-1:0]   TILT_THR_RST       = THR_W'(230);
  localparam logic [NORM_W-1:0]  NORM_LOW_RST       = NORM_W'(235);
  localparam logic [NORM_W-1:0]  NORM_HIGH_RST      = NORM_W'(275);
  localparam logic [LIMIT_W-1:0] REPEAT_LIMIT_RST   = LIMIT_W'(3);
  localparam logic [LO_SQ_W-1:0] LO_SQ_RST = LO_SQ_W'((235 + 1) * (235 + 1));
  localparam logic [HI_SQ_W-1:0] HI_SQ_RST = HI_SQ_W'(275 * 275);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILT_THR       = 2'd0,
    CFG_NORM_LOW       = 2'd1,
    CFG_NORM_HIGH      = 2'd2,
    CFG_REPEAT_LIMIT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef enum logic [1:0] {
    EVT_NONE      = 2'd0,
    EVT_X_UPRIGHT = 2'd1,
    EVT_Y_ALARM   = 2'd2,
    EVT_Z_WARNING = 2'd3
  } event_kind_e;

  // Per-axis result of the first stage
  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            over;
  } axis_info_t;

endpackage

`default_nettype wire

// ===== rtl/core/tod_axis.sv =====
`default_nettype none

module tod_axis (
  input  wire logic signed [tod_pkg::ACCEL_W-1:0] accel_i,
  input  wire logic        [tod_pkg::THR_W-1:0]   thr_i,
  output tod_pkg::axis_info_t                      info_o
);

  logic signed [2*tod_pkg::ACCEL_W-1:0] prod;
  logic signed [tod_pkg::ACCEL_W:0]     accel_ext;
  logic signed [tod_pkg::ACCEL_W:0]     thr_pos;
  logic signed [tod_pkg::ACCEL_W:0]     thr_neg;

  // Square the sample; the result is never negative
  assign prod = (2*tod_pkg::ACCEL_W)'(accel_i) * (2*tod_pkg::ACCEL_W)'(accel_i);
  assign info_o.sq = prod[tod_pkg::SQ_W-1:0];

  // Compare magnitude against the threshold on both sides of zero
  assign accel_ext = {accel_i[tod_pkg::ACCEL_W-1], accel_i};
  assign thr_pos   = $signed({2'b00, thr_i});
  assign thr_neg   = -thr_pos;
  assign info_o.over = (accel_ext > thr_pos) || (accel_ext < thr_neg);

endmodule

`default_nettype wire

// ===== rtl/core/tilt_orientation_detector_core.sv =====
// Tilt orientation detector.
// Input channel: in_valid_i with accel_x_i, accel_y_i, accel_z_i (10-bit two's
// complement); a transaction completes when in_valid_i is high and in_stall_o
// is low. Output channel: out_valid_o with event_kind_o; a transaction
// completes when out_valid_o is high and out_stall_i is low. Every input
// sample yields exactly one result (event_kind 0 when nothing fires).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 tilt threshold, 1 norm_low, 2 norm_high, 3 repeat_limit) at the clock
// edge; write only while no sample is in flight.
// Pipeline: three stages (input register, squares register, result register),
// passed in that order. Throughput: one sample per cycle while the receiver
// does not stall.
// Stall: each stage holds its transaction while the next is full, so up to
// three samples are buffered; in_stall_o rises only when all stages are full
// and the receiver stalls.
// Reset (rst_ni low, asynchronous): pipeline empties, registers take their
// reset values, no dominant axis, repeat count zero.
`default_nettype none

module tilt_orientation_detector_core (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic        [tod_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic        [tod_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                                   in_valid_i,
  output      logic                                   in_stall_o,
  input  wire logic signed [tod_pkg::ACCEL_W-1:0]     accel_x_i,
  input  wire logic signed [tod_pkg::ACCEL_W-1:0]     accel_y_i,
  input  wire logic signed [tod_pkg::ACCEL_W-1:0]     accel_z_i,
  output      logic                                   out_valid_o,
  input  wire logic                                   out_stall_i,
  output      logic        [1:0]                      event_kind_o
);

  // Configuration registers
  logic [tod_pkg::THR_W-1:0]   thr_q;
  logic [tod_pkg::NORM_W-1:0]  norm_low_q;
  logic [tod_pkg::NORM_W-1:0]  norm_high_q;
  logic [tod_pkg::LIMIT_W-1:0] limit_q;
  logic [tod_pkg::LO_SQ_W-1:0] lo_sq_q, lo_sq_d;
  logic [tod_pkg::HI_SQ_W-1:0] hi_sq_q, hi_sq_d;
  logic [tod_pkg::NORM_W:0]    norm_low_inc;
  logic [2*tod_pkg::NORM_W+1:0] lo_prod;
  logic [2*tod_pkg::NORM_W-1:0] hi_prod;

  // Pipeline
  logic v0_q, v1_q, out_valid_q;
  logic rdy0, rdy1, rdy2;
  logic signed [tod_pkg::ACCEL_W-1:0] acc_q [tod_pkg::NUM_AXES];
  tod_pkg::axis_info_t info_d [tod_pkg::NUM_AXES];
  tod_pkg::axis_info_t info_q [tod_pkg::NUM_AXES];
  logic [1:0] kind_q;

  // Orientation state
  tod_pkg::axis_e              dom_q, dom_d;
  logic [tod_pkg::LIMIT_W-1:0] cnt_q, cnt_d;
  tod_pkg::event_kind_e        kind_d;
  logic [tod_pkg::SUM_W-1:0]   sum;
  logic                        in_win;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= tod_pkg::TILT_THR_RST;
      norm_low_q  <= tod_pkg::NORM_LOW_RST;
      norm_high_q <= tod_pkg::NORM_HIGH_RST;
      limit_q     <= tod_pkg::REPEAT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (tod_pkg::cfg_idx_e'(cfg_idx_i))
        tod_pkg::CFG_TILT_THR:       thr_q       <= cfg_data_i[tod_pkg::THR_W-1:0];
        tod_pkg::CFG_NORM_LOW:       norm_low_q  <= cfg_data_i[tod_pkg::NORM_W-1:0];
        tod_pkg::CFG_NORM_HIGH:      norm_high_q <= cfg_data_i[tod_pkg::NORM_W-1:0];
        tod_pkg::CFG_REPEAT_LIMIT:   limit_q     <= cfg_data_i[tod_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Square the window bounds; the squares are registered in the cycle after the bounds are written
  assign norm_low_inc = {1'b0, norm_low_q} + (tod_pkg::NORM_W+1)'(1);
  assign lo_prod      = (2*tod_pkg::NORM_W+2)'(norm_low_inc)
                      * (2*tod_pkg::NORM_W+2)'(norm_low_inc);
  assign hi_prod      = (2*tod_pkg::NORM_W)'(norm_high_q) * (2*tod_pkg::NORM_W)'(norm_high_q);
  assign lo_sq_d      = lo_prod[tod_pkg::LO_SQ_W-1:0];
  assign hi_sq_d      = hi_prod[tod_pkg::HI_SQ_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_sq_q <= tod_pkg::LO_SQ_RST;
      hi_sq_q <= tod_pkg::HI_SQ_RST;
    end else begin
      lo_sq_q <= lo_sq_d;
      hi_sq_q <= hi_sq_d;
    end
  end

  // Stage handshake: a stage takes a transaction when empty or draining
  assign rdy2        = !out_valid_q || !out_stall_i;
  assign rdy1        = !v1_q || rdy2;
  assign rdy0        = !v0_q || rdy1;
  assign in_stall_o  = !rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy0) v0_q        <= in_valid_i;
      if (rdy1) v1_q        <= v0_q;
      if (rdy2) out_valid_q <= v1_q;
    end
  end

  // Capture the input sample
  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      acc_q[0] <= accel_x_i;
      acc_q[1] <= accel_y_i;
      acc_q[2] <= accel_z_i;
    end
  end

  // Square and threshold each axis
  for (genvar g = 0; g < tod_pkg::NUM_AXES; g++) begin : g_axis
    tod_axis u_axis (
      .accel_i (acc_q[g]),
      .thr_i   (thr_q),
      .info_o  (info_d[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      info_q <= info_d;
    end
  end

  // Window test and dominant-axis update
  assign sum = tod_pkg::SUM_W'(info_q[0].sq) + tod_pkg::SUM_W'(info_q[1].sq)
             + tod_pkg::SUM_W'(info_q[2].sq);
  assign in_win = ({1'b0, sum} >= lo_sq_q) && (sum < hi_sq_q);

  always_comb begin
    dom_d  = dom_q;
    cnt_d  = cnt_q;
    kind_d = tod_pkg::EVT_NONE;
    for (int i = 0; i < tod_pkg::NUM_AXES; i++) begin
      if (in_win && info_q[i].over) begin
        if (dom_d == tod_pkg::axis_e'(2'(i))) begin
          if (cnt_d < limit_q) cnt_d = cnt_d + tod_pkg::LIMIT_W'(1);
        end else begin
          dom_d = tod_pkg::axis_e'(2'(i));
          cnt_d = '0;
        end
      end
    end
    // Fire when the count reaches the limit, then move past it (a limit of 15 wraps to zero)
    if (cnt_d == limit_q) begin
      cnt_d = limit_q + tod_pkg::LIMIT_W'(1);
      case (dom_d)
        tod_pkg::AXIS_X: kind_d = tod_pkg::EVT_X_UPRIGHT;
        tod_pkg::AXIS_Y: kind_d = tod_pkg::EVT_Y_ALARM;
        tod_pkg::AXIS_Z: kind_d = tod_pkg::EVT_Z_WARNING;
        default:         kind_d = tod_pkg::EVT_NONE;
      endcase
    end
  end

  // Advance state as the transaction enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_q <= tod_pkg::AXIS_NONE;
      cnt_q <= '0;
    end else if (rdy2 && v1_q) begin
      dom_q <= dom_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      kind_q <= kind_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;

`ifndef ASSERT_OFF
  // An event always names an axis that has been seen
  a_event_has_axis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != tod_pkg::EVT_NONE) |-> dom_q != tod_pkg::AXIS_NONE)
    else $error("event reported with no dominant axis");

  // A full pipeline facing a stalled receiver holds off the sender
  a_full_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && v1_q && v0_q |-> in_stall_o)
    else $error("input not stalled with pipeline full");

  // A new result comes only from the squares stage
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v1_q))
    else $error("result appeared without a transaction in flight");
`endif

endmodule

`default_nettype wire
